FILE: rtl/dmcl_pkg.sv
package dmcl_pkg;

  localparam int ADDR_WIDTH  = 32;
  localparam int TAG_W       = 32;
  localparam int IDX_W       = 10;
  localparam int OFF_W       = 16;
  localparam int CNT_W       = 32;
  localparam int OB_W        = 5;
  localparam int IB_W        = 4;
  localparam int CFG_W       = 5;
  localparam int CFG_IDX_W   = 1;
  localparam int OUT_DATA_W  = 128;
  localparam int OUT_PAD_W   = OUT_DATA_W - (TAG_W + IDX_W + OFF_W + 2 * CNT_W);
  localparam int DEF_ENTRIES = 1024;

  localparam logic [OB_W-1:0] OFFSET_MAX = OB_W'(16);
  localparam logic [IB_W-1:0] INDEX_MAX  = IB_W'(10);

  localparam logic [OB_W-1:0] OFFSET_RESET = OB_W'(4);
  localparam logic [IB_W-1:0] INDEX_RESET  = IB_W'(10);

  localparam logic [CFG_IDX_W-1:0] REG_OFFSET_BITS = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_INDEX_BITS  = 1'b1;

  typedef struct packed {
    logic clear;
    logic load;
    logic split;
    logic slot;
    logic read;
    logic commit;
  } cmd_t;

  typedef struct packed {
    logic clear_done;
    logic out_free;
  } status_t;

endpackage

FILE: rtl/dmcl_ctrl.sv
module dmcl_ctrl
  import dmcl_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    s_tvalid,
  output logic    s_tready,
  input  status_t st,
  output cmd_t    cmd
);

  localparam logic [2:0] S_CLEAR = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_SPLIT = 3'd2;
  localparam logic [2:0] S_SLOT  = 3'd3;
  localparam logic [2:0] S_READ  = 3'd4;
  localparam logic [2:0] S_CMP   = 3'd5;

  logic [2:0] state;
  logic [2:0] state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  assign s_tready = (state == S_IDLE);

  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      S_CLEAR: begin
        cmd.clear = 1'b1;
        if (st.clear_done) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        if (s_tvalid) begin
          cmd.load   = 1'b1;
          state_next = S_SPLIT;
        end
      end
      S_SPLIT: begin
        cmd.split  = 1'b1;
        state_next = S_SLOT;
      end
      S_SLOT: begin
        cmd.slot   = 1'b1;
        state_next = S_READ;
      end
      S_READ: begin
        cmd.read   = 1'b1;
        state_next = S_CMP;
      end
      S_CMP: begin
        if (st.out_free) begin
          cmd.commit = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_CLEAR;
      end
    endcase
  end

endmodule

FILE: rtl/dmcl_dp.sv
module dmcl_dp
  import dmcl_pkg::*;
#(
  parameter int ENTRIES = DEF_ENTRIES
) (
  input  logic                   clk,
  input  logic                   rst,
  input  cmd_t                   cmd,
  output status_t                st,
  input  logic                   cfg_we,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic [CFG_W-1:0]       cfg_data,
  input  logic [ADDR_WIDTH-1:0]  address,
  output logic                   m_tvalid,
  input  logic                   m_tready,
  output logic                   hit,
  output logic [TAG_W-1:0]       tag_value,
  output logic [IDX_W-1:0]       index_value,
  output logic [OFF_W-1:0]       offset_value,
  output logic [CNT_W-1:0]       access_total,
  output logic [CNT_W-1:0]       hit_total
);

  localparam int SLOTS    = (ENTRIES < (1 << IDX_W)) ? ENTRIES : (1 << IDX_W);
  localparam int SLOT_W   = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int CLR_W    = $clog2(SLOTS + 1);
  localparam int SHIFT    = 2 * IDX_W;
  localparam int RECIP_W  = SHIFT + 1;
  localparam int PROD_W   = IDX_W + RECIP_W;
  localparam longint RECIP_VAL = ((64'd1 << SHIFT) + ENTRIES - 1) / ENTRIES;
  localparam logic [RECIP_W-1:0] RECIP   = RECIP_W'(RECIP_VAL);
  localparam logic [IDX_W-1:0]   ENT_LOW = IDX_W'(ENTRIES % (1 << IDX_W));
  localparam logic [CLR_W-1:0]   CLR_LAST = CLR_W'(SLOTS - 1);

  logic [OB_W-1:0]       offset_bits;
  logic [IB_W-1:0]       index_bits;
  logic [ADDR_WIDTH-1:0] addr;
  logic [PROD_W-1:0]     prod;
  logic [SLOT_W-1:0]     slot;
  logic [TAG_W-1:0]      rd_tag;
  logic                  rd_valid;
  logic [CLR_W-1:0]      clr_cnt;
  logic [CNT_W-1:0]      access_cnt;
  logic [CNT_W-1:0]      hit_cnt;
  logic                  out_valid;
  logic                  hit_flag;
  logic [TAG_W-1:0]      tag_reg;
  logic [IDX_W-1:0]      idx_reg;
  logic [OFF_W-1:0]      off_reg;

  logic [TAG_W-1:0] tag_mem   [SLOTS];
  logic             valid_mem [SLOTS];

  logic [OB_W-1:0]       ob;
  logic [IB_W-1:0]       ib;
  logic [OB_W:0]         sh_tag;
  logic [ADDR_WIDTH-1:0] addr_sh;
  logic [ADDR_WIDTH-1:0] off_mask;
  logic [ADDR_WIDTH-1:0] idx_mask;
  logic [IDX_W-1:0]      idx_comb;
  logic [IDX_W-1:0]      quot;
  logic [IDX_W-1:0]      qd;
  logic [IDX_W-1:0]      rem;
  logic                  hit_now;
  logic                  vld_we;
  logic [SLOT_W-1:0]     vld_addr;
  logic                  vld_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      offset_bits <= OFFSET_RESET;
      index_bits  <= INDEX_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_OFFSET_BITS: offset_bits <= cfg_data;
        REG_INDEX_BITS:  index_bits  <= cfg_data[IB_W-1:0];
        default: ;
      endcase
    end
  end

  // field split
  assign ob       = (offset_bits > OFFSET_MAX) ? OFFSET_MAX : offset_bits;
  assign ib       = (index_bits > INDEX_MAX) ? INDEX_MAX : index_bits;
  assign sh_tag   = {1'b0, ob} + {2'b00, ib};
  assign addr_sh  = addr >> ob;
  assign off_mask = ~({ADDR_WIDTH{1'b1}} << ob);
  assign idx_mask = ~({ADDR_WIDTH{1'b1}} << ib);
  assign idx_comb = IDX_W'(addr_sh & idx_mask);

  // slot = index mod ENTRIES by reciprocal multiply
  assign quot = prod[SHIFT +: IDX_W];
  assign qd   = IDX_W'(quot * ENT_LOW);
  assign rem  = idx_reg - qd;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      addr <= address;
    end
    if (cmd.split) begin
      off_reg <= OFF_W'(addr & off_mask);
      idx_reg <= idx_comb;
      tag_reg <= TAG_W'(addr >> sh_tag);
      prod    <= PROD_W'(idx_comb * RECIP);
    end
    if (cmd.slot) begin
      slot <= rem[SLOT_W-1:0];
    end
  end

  assign hit_now = rd_valid && (rd_tag == tag_reg);

  always_ff @(posedge clk) begin
    if (cmd.read) begin
      rd_tag <= tag_mem[slot];
    end
    if (cmd.commit && !hit_now) begin
      tag_mem[slot] <= tag_reg;
    end
  end

  assign vld_we   = cmd.clear || (cmd.commit && !hit_now);
  assign vld_addr = cmd.clear ? clr_cnt[SLOT_W-1:0] : slot;
  assign vld_data = !cmd.clear;

  always_ff @(posedge clk) begin
    if (cmd.read) begin
      rd_valid <= valid_mem[slot];
    end
    if (vld_we) begin
      valid_mem[vld_addr] <= vld_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_cnt <= '0;
    end else if (cmd.clear && !st.clear_done) begin
      clr_cnt <= clr_cnt + CLR_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      access_cnt <= '0;
      hit_cnt    <= '0;
      out_valid  <= 1'b0;
    end else begin
      if (cmd.commit) begin
        out_valid <= 1'b1;
        if (access_cnt != '1) begin
          access_cnt <= access_cnt + CNT_W'(1);
        end
        if (hit_now && (hit_cnt != '1)) begin
          hit_cnt <= hit_cnt + CNT_W'(1);
        end
      end else if (m_tready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // output item register, held while the receiver stalls
  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      hit_flag     <= hit_now;
      tag_value    <= tag_reg;
      index_value  <= idx_reg;
      offset_value <= off_reg;
    end
  end

  assign st.clear_done = (clr_cnt == CLR_LAST);
  assign st.out_free   = !out_valid || m_tready;

  assign m_tvalid     = out_valid;
  assign hit          = hit_flag;
  assign access_total = access_cnt;
  assign hit_total    = hit_cnt;

endmodule

FILE: rtl/direct_mapped_cache_lookup.sv
// Direct-mapped cache tag lookup, one address item in, one result item out.
// Each item passes accept, split, slot reduce, tag/valid read, and compare and
// update; a new item is accepted only after the previous one is committed. A
// result held in the output register stalls compare.
// Reset: synchronous; afterwards a valid-bit clearing pass over min(ENTRIES, 1024)
// slots runs with tready low. Config writes are taken throughout.
module direct_mapped_cache_lookup
  import dmcl_pkg::*;
#(
  parameter int ENTRIES = DEF_ENTRIES
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_W-1:0]      cfg_data,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  logic [ADDR_WIDTH-1:0] s_tdata,   // address
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output logic [OUT_DATA_W-1:0] m_tdata,   // tag_value, index_value, offset_value,
                                           // access_total, hit_total, zero pad
  output logic [0:0]            m_tuser    // hit
);

  cmd_t    cmd;
  status_t st;

  logic             hit;
  logic [TAG_W-1:0] tag_value;
  logic [IDX_W-1:0] index_value;
  logic [OFF_W-1:0] offset_value;
  logic [CNT_W-1:0] access_total;
  logic [CNT_W-1:0] hit_total;

  dmcl_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .st       (st),
    .cmd      (cmd)
  );

  dmcl_dp #(
    .ENTRIES (ENTRIES)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .st           (st),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .address      (s_tdata),
    .m_tvalid     (m_tvalid),
    .m_tready     (m_tready),
    .hit          (hit),
    .tag_value    (tag_value),
    .index_value  (index_value),
    .offset_value (offset_value),
    .access_total (access_total),
    .hit_total    (hit_total)
  );

  assign m_tdata = {{OUT_PAD_W{1'b0}}, hit_total, access_total, offset_value,
                    index_value, tag_value};
  assign m_tuser = hit;

endmodule

FILE: rtl/dmcl_checker.sv
module dmcl_checker
  import dmcl_pkg::*;
(
  input logic                  clk,
  input logic                  rst,
  input logic                  s_tready,
  input logic                  m_tvalid,
  input logic                  m_tready,
  input logic [OUT_DATA_W-1:0] m_tdata,
  input logic [0:0]            m_tuser
);

  logic [CNT_W-1:0] acc_tot;
  logic [CNT_W-1:0] hit_tot;

  assign acc_tot = m_tdata[TAG_W+IDX_W+OFF_W +: CNT_W];
  assign hit_tot = m_tdata[TAG_W+IDX_W+OFF_W+CNT_W +: CNT_W];

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid)
    else $error("output item dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> $stable(m_tdata) && $stable(m_tuser))
    else $error("output item changed while stalled");

  a_hits_le_access: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> hit_tot <= acc_tot)
    else $error("hit count exceeds access count");

  a_hit_counted: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser[0] |-> hit_tot != '0)
    else $error("hit reported with zero hit count");

  a_clear_after_reset: assert property (@(posedge clk)
    $past(rst) |-> !s_tready && !m_tvalid)
    else $error("block active right after reset");

endmodule

bind direct_mapped_cache_lookup dmcl_checker u_chk (.*);
